### rtl/xasp_pkg.sv
// ----------------------------------------------------------------------------
// xasp_pkg
// shared types and constants of the xor archive stream parser
// ----------------------------------------------------------------------------
package xasp_pkg;

    localparam logic [7:0]  XOR_KEY      = 8'hF7;
    localparam logic [7:0]  END_FLAG     = 8'h80;
    localparam logic [31:0] MAGIC_WORD   = 32'hBAC04AC0;
    localparam logic [31:0] VERSION_WORD = 32'h0000_0000;

    localparam logic [7:0]  LEN_WORD  = 8'd4;
    localparam logic [7:0]  LEN_TIME  = 8'd8;
    localparam logic [7:0]  LEN_BYTE  = 8'd1;

    localparam logic [3:0] KIND_MAGIC   = 4'd0;
    localparam logic [3:0] KIND_VERSION = 4'd1;
    localparam logic [3:0] KIND_FLAG    = 4'd2;
    localparam logic [3:0] KIND_NLEN    = 4'd3;
    localparam logic [3:0] KIND_NAME    = 4'd4;
    localparam logic [3:0] KIND_SIZE    = 4'd5;
    localparam logic [3:0] KIND_TIME    = 4'd6;
    localparam logic [3:0] KIND_HDR_END = 4'd7;
    localparam logic [3:0] KIND_BODY    = 4'd8;
    localparam logic [3:0] KIND_IGNORED = 4'd9;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_MAGIC   = 3'd1;
    localparam logic [2:0] ERR_VERSION = 3'd2;
    localparam logic [2:0] ERR_END     = 3'd3;
    localparam logic [2:0] ERR_ENTRIES = 3'd4;

    typedef enum logic [8:0] {
        PH_MAGIC   = 9'b000000001,
        PH_VERSION = 9'b000000010,
        PH_FLAG    = 9'b000000100,
        PH_NLEN    = 9'b000001000,
        PH_NAME    = 9'b000010000,
        PH_SIZE    = 9'b000100000,
        PH_TIME    = 9'b001000000,
        PH_BODY    = 9'b010000000,
        PH_DONE    = 9'b100000000
    } phase_t;

    // one queued nonempty file: its entry number and size
    typedef struct packed {
        logic [5:0]  entry;
        logic [31:0] size;
    } slot_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] kind;
        logic [5:0] entry_number;
        logic [7:0] field_offset;
        logic       last_of_field;
        logic [2:0] error_code;
    } res_t;

endpackage

### rtl/xor_archive_stream_parser_top.sv
// ----------------------------------------------------------------------------
// xor_archive_stream_parser_top
// decodes an obfuscated archive byte stream and tags every byte
//
//   channel   direction  handshake               payload
//   raw       in         raw_valid / raw_stall   raw_byte
//   res       out        res_valid / res_stall   data_byte .. error_code
//   cfg       in         cfg_we                  cfg_wdata (archive length)
//
// one request per cycle sustained while res_stall is low; a taken request
// passes the input register, then the parse step into the result register
// the body file sizes come from a queue ram read ahead at the next head
// reset clears all control state; no clearing pass is needed
// a stalled result side fills the skid entry, then stalls the raw side
// ----------------------------------------------------------------------------
module xor_archive_stream_parser_top
    import xasp_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        raw_valid,
    output logic        raw_stall,
    input  logic [7:0]  raw_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  data_byte,
    output logic [3:0]  kind,
    output logic [5:0]  entry_number,
    output logic [7:0]  field_offset,
    output logic        last_of_field,
    output logic [2:0]  error_code
);

    logic buf_ready;
    logic res_push;
    res_t res;
    res_t dout;

    xasp_core #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_stall (raw_stall),
        .raw_byte  (raw_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .buf_ready (buf_ready),
        .res_push  (res_push),
        .res       (res)
    );

    xasp_res_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .din       (res),
        .ready     (buf_ready),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .dout      (dout)
    );

    assign data_byte     = dout.data_byte;
    assign kind          = dout.kind;
    assign entry_number  = dout.entry_number;
    assign field_offset  = dout.field_offset;
    assign last_of_field = dout.last_of_field;
    assign error_code    = dout.error_code;

endmodule

### rtl/xasp_ram.sv
// ----------------------------------------------------------------------------
// xasp_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module xasp_ram
    import xasp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/xasp_core.sv
// ----------------------------------------------------------------------------
// xasp_core
// input register, header and body parse step, queue of nonempty files
// ----------------------------------------------------------------------------
module xasp_core
    import xasp_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        raw_valid,
    output logic        raw_stall,
    input  logic [7:0]  raw_byte,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        buf_ready,
    output logic        res_push,
    output res_t        res
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;

    phase_t      phase_reg,     phase_next;
    logic [7:0]  pos_reg,       pos_next;
    logic [7:0]  nlen_reg,      nlen_next;
    logic [31:0] asm_reg,       asm_next;
    logic [CW-1:0] cnt_reg,     cnt_next;
    logic [31:0] brem_reg,      brem_next;
    logic [31:0] body_rem_reg,  body_rem_next;
    logic [2:0]  err_reg,       err_next;
    logic [CW-1:0] wr_ptr_reg,  wr_ptr_next;
    logic [CW-1:0] rd_ptr_reg,  rd_ptr_next;

    logic        fire;
    logic [7:0]  d;
    logic [7:0]  flen;
    logic [31:0] asm_base;
    logic [31:0] asm_new;
    logic [31:0] rem_cur;
    logic        push;
    logic [2:0]  err;
    slot_t       head;
    logic [$bits(slot_t)-1:0] rdata;

    assign raw_stall = in_vld_reg && !buf_ready;
    assign fire      = in_vld_reg && buf_ready;
    assign d         = in_byte_reg ^ XOR_KEY;
    assign head      = slot_t'(rdata);
    assign res_push  = fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!raw_stall)
        begin
            in_vld_reg <= raw_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw_valid && !raw_stall)
        begin
            in_byte_reg <= raw_byte;
        end
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_MAGIC, PH_VERSION, PH_SIZE: flen = LEN_WORD;
            PH_TIME:                       flen = LEN_TIME;
            PH_NAME:                       flen = nlen_reg;
            default:                       flen = LEN_BYTE;
        endcase
    end

    assign asm_base = (pos_reg == 8'd0) ? 32'd0 : asm_reg;
    assign asm_new  = (pos_reg < LEN_WORD)
                    ? (asm_base | ({24'd0, d} << {pos_reg[1:0], 3'b000}))
                    : asm_base;
    assign rem_cur  = (body_rem_reg == 32'd0) ? head.size : body_rem_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        nlen_next     = nlen_reg;
        asm_next      = asm_reg;
        cnt_next      = cnt_reg;
        brem_next     = brem_reg;
        body_rem_next = body_rem_reg;
        err_next      = err_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        push          = 1'b0;
        err           = ERR_NONE;

        res.data_byte     = d;
        res.kind          = KIND_IGNORED;
        res.entry_number  = 6'd0;
        res.field_offset  = 8'd0;
        res.last_of_field = 1'b0;
        res.error_code    = ERR_NONE;

        if (fire)
        begin
            if (err_reg != ERR_NONE || phase_reg == PH_DONE)
            begin
                res.error_code = err_reg;
            end
            else if (phase_reg == PH_BODY)
            begin
                res.kind         = KIND_BODY;
                res.entry_number = head.entry;
                if (body_rem_reg == 32'd0 && brem_reg < head.size)
                begin
                    err = ERR_END;
                end
                else
                begin
                    res.field_offset = (body_rem_reg == 32'd0) ? 8'd0
                                     : head.size[7:0] - body_rem_reg[7:0];
                    body_rem_next = rem_cur - 32'd1;
                    if (rem_cur == 32'd1)
                    begin
                        res.last_of_field = 1'b1;
                        rd_ptr_next = rd_ptr_reg + CW'(1);
                        if (CW'(rd_ptr_reg + CW'(1)) == wr_ptr_reg)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
            end
            else
            begin
                res.field_offset = pos_reg;
                res.entry_number = (phase_reg == PH_MAGIC || phase_reg == PH_VERSION)
                                 ? 6'd0 : 6'(cnt_reg);
                unique case (phase_reg)
                    PH_MAGIC:   res.kind = KIND_MAGIC;
                    PH_VERSION: res.kind = KIND_VERSION;
                    PH_FLAG:    res.kind = KIND_FLAG;
                    PH_NLEN:    res.kind = KIND_NLEN;
                    PH_NAME:    res.kind = KIND_NAME;
                    PH_SIZE:    res.kind = KIND_SIZE;
                    PH_TIME:    res.kind = KIND_TIME;
                    default:    res.kind = KIND_IGNORED;
                endcase

                if (pos_reg == 8'd0 && brem_reg < {24'd0, flen})
                begin
                    err = ERR_END;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_MAGIC, PH_VERSION, PH_SIZE, PH_TIME:
                        begin
                            asm_next = asm_new;
                            if (pos_reg == flen - 8'd1)
                            begin
                                res.last_of_field = 1'b1;
                                pos_next = 8'd0;
                                if (phase_reg == PH_MAGIC)
                                begin
                                    if (asm_new != MAGIC_WORD)
                                    begin
                                        err = ERR_MAGIC;
                                        res.last_of_field = 1'b0;
                                    end
                                    else
                                    begin
                                        phase_next = PH_VERSION;
                                    end
                                end
                                else if (phase_reg == PH_VERSION)
                                begin
                                    if (asm_new != VERSION_WORD)
                                    begin
                                        err = ERR_VERSION;
                                        res.last_of_field = 1'b0;
                                    end
                                    else
                                    begin
                                        phase_next = PH_FLAG;
                                    end
                                end
                                else if (phase_reg == PH_SIZE)
                                begin
                                    if (asm_new != 32'd0)
                                    begin
                                        push        = 1'b1;
                                        wr_ptr_next = wr_ptr_reg + CW'(1);
                                    end
                                    phase_next = PH_TIME;
                                end
                                else
                                begin
                                    cnt_next   = cnt_reg + CW'(1);
                                    phase_next = PH_FLAG;
                                end
                            end
                            else
                            begin
                                pos_next = pos_reg + 8'd1;
                            end
                        end
                        PH_FLAG:
                        begin
                            if (d == END_FLAG)
                            begin
                                res.kind          = KIND_HDR_END;
                                res.last_of_field = 1'b1;
                                body_rem_next     = 32'd0;
                                phase_next = (wr_ptr_reg == CW'(0)) ? PH_DONE : PH_BODY;
                            end
                            else if (cnt_reg >= CW'(MAX_ENTRIES))
                            begin
                                err = ERR_ENTRIES;
                            end
                            else
                            begin
                                res.last_of_field = 1'b1;
                                phase_next = PH_NLEN;
                            end
                        end
                        PH_NLEN:
                        begin
                            nlen_next         = d;
                            res.last_of_field = 1'b1;
                            pos_next          = 8'd0;
                            phase_next = (d != 8'd0) ? PH_NAME : PH_SIZE;
                        end
                        PH_NAME:
                        begin
                            if ({1'b0, pos_reg} + 9'd1 >= {1'b0, nlen_reg})
                            begin
                                res.last_of_field = 1'b1;
                                pos_next   = 8'd0;
                                phase_next = PH_SIZE;
                            end
                            else
                            begin
                                pos_next = pos_reg + 8'd1;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end

            res.error_code = (err != ERR_NONE) ? err : res.error_code;
            if (err != ERR_NONE)
            begin
                err_next = err;
            end
            else if (brem_reg != 32'd0)
            begin
                brem_next = brem_reg - 32'd1;
            end
        end

        if (cfg_we)
        begin
            brem_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC;
            pos_reg      <= 8'd0;
            nlen_reg     <= 8'd0;
            asm_reg      <= 32'd0;
            cnt_reg      <= '0;
            brem_reg     <= 32'd0;
            body_rem_reg <= 32'd0;
            err_reg      <= ERR_NONE;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            nlen_reg     <= nlen_next;
            asm_reg      <= asm_next;
            cnt_reg      <= cnt_next;
            brem_reg     <= brem_next;
            body_rem_reg <= body_rem_next;
            err_reg      <= err_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
        end
    end

    // queue of nonempty files, read ahead at the next head
    xasp_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_queue (
        .clk   (clk),
        .we    (push),
        .waddr (wr_ptr_reg[AW-1:0]),
        .wdata ({6'(cnt_reg), asm_new}),
        .raddr (rd_ptr_next[AW-1:0]),
        .rdata (rdata)
    );

endmodule

### rtl/xasp_res_buf.sv
// ----------------------------------------------------------------------------
// xasp_res_buf
// result register with a skid entry
// ----------------------------------------------------------------------------
module xasp_res_buf
    import xasp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t din,
    output logic ready,
    output logic res_valid,
    input  logic res_stall,
    output res_t dout
);

    logic [1:0] count_reg, count_next;
    res_t       main_reg,  main_next;
    res_t       skid_reg,  skid_next;
    logic       pop;

    assign pop       = (count_reg != 2'd0) && !res_stall;
    assign ready     = (count_reg != 2'd2);
    assign res_valid = (count_reg != 2'd0);
    assign dout      = main_reg;

    always_comb
    begin
        count_next = count_reg;
        main_next  = main_reg;
        skid_next  = skid_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    main_next  = din;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    main_next = din;
                end
                else if (push)
                begin
                    skid_next  = din;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    main_next  = skid_reg;
                    count_next = 2'd1;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

### rtl/xasp_checker.sv
// ----------------------------------------------------------------------------
// xasp_checker
// port level checks of the xor archive stream parser
// ----------------------------------------------------------------------------
module xasp_checker
    import xasp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_stall,
    input logic [7:0] data_byte,
    input logic [3:0] kind,
    input logic [5:0] entry_number,
    input logic [7:0] field_offset,
    input logic       last_of_field,
    input logic [2:0] error_code
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(data_byte) && $stable(kind)
            && $stable(entry_number) && $stable(field_offset)
            && $stable(last_of_field) && $stable(error_code))
        else $error("result changed while stalled");

    a_ignored_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_IGNORED |->
            !last_of_field && entry_number == 6'd0 && field_offset == 8'd0)
        else $error("ignored byte carries field information");

    a_error_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && error_code != ERR_NONE && kind != KIND_IGNORED |-> !last_of_field)
        else $error("error byte flagged as last of field");

    a_hdr_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_HDR_END |-> last_of_field && error_code == ERR_NONE)
        else $error("header end byte malformed");

    a_preamble_entry: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (kind == KIND_MAGIC || kind == KIND_VERSION) |-> entry_number == 6'd0)
        else $error("magic or version byte with nonzero entry");

endmodule

bind xor_archive_stream_parser_top xasp_checker u_xasp_checker (.*);
